@@ rtl/bsc_pkg.sv @@
package bsc_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int POOL_DEPTH  = 256;
  localparam int VALUE_WIDTH = 32;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 8;
  localparam int PV_W    = 32;
  localparam int STAT_W  = 2;
  localparam int RET_W   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_NEG   = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_SUB   = 3'd3,
    CMD_MUL   = 3'd4,
    CMD_DIV   = 3'd5,
    CMD_RET   = 3'd6,
    CMD_WPOOL = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctl_t;

endpackage

@@ rtl/bsc_ram.sv @@
module bsc_ram #(
  parameter int WIDTH = bsc_pkg::VALUE_WIDTH,
  parameter int DEPTH = bsc_pkg::STACK_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bsc_muldiv.sv @@
module bsc_muldiv #(
  parameter int VALUE_WIDTH = bsc_pkg::VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bsc_pkg::md_ctl_t       ctl,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int VW = VALUE_WIDTH;
  localparam int SW = $clog2(VW);

  logic          busy_r, done_r, div_r, neg_r;
  logic [SW-1:0] step_r;
  logic [VW-1:0] acc_r, x_r, y_r;

  logic [VW-1:0] acc_nxt, x_nxt, y_nxt;
  logic [VW:0]   trial;
  logic          qbit;
  logic [VW-1:0] mag_a, mag_b;

  assign mag_a = a[VW-1] ? (VW'(0) - a) : a;
  assign mag_b = b[VW-1] ? (VW'(0) - b) : b;

  // one bit per step: shift-add multiply, restoring divide on magnitudes
  always_comb begin
    trial   = {acc_r, x_r[VW-1]} - {1'b0, y_r};
    qbit    = ~trial[VW];
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    if (div_r) begin
      acc_nxt = qbit ? trial[VW-1:0] : {acc_r[VW-2:0], x_r[VW-1]};
      x_nxt   = {x_r[VW-2:0], qbit};
    end else begin
      acc_nxt = x_r[0] ? (acc_r + y_r) : acc_r;
      x_nxt   = {1'b0, x_r[VW-1:1]};
      y_nxt   = {y_r[VW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        div_r  <= ctl.is_div;
        neg_r  <= a[VW-1] ^ b[VW-1];
        acc_r  <= '0;
        x_r    <= ctl.is_div ? mag_a : b;
        y_r    <= ctl.is_div ? mag_b : a;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        step_r <= step_r + SW'(1);
        if (step_r == SW'(VW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = div_r ? (neg_r ? (VW'(0) - x_r) : x_r) : acc_r;

endmodule

@@ rtl/bytecode_stack_calculator_top.sv @@
// Bytecode stack calculator: runs one stack-machine instruction per request.
// Input channel (in_valid/in_ready): in_cmd, in_pool_index, in_pool_value.
// Result channel (out_valid/out_ready): one result per instruction, carrying
// out_status, out_ret_valid, out_ret_value and out_finished.
// The top of stack sits in a register, the rest of the stack and the
// constant pool in two RAMs with a registered read. Operands are
// read in the accept cycle and used in the next one, in S_EXEC.
// Push, negate, add, sub, return, pool write and any faulting instruction:
// the RAM read is followed by the write-back in S_EXEC.
// Mul and div without a fault wait in S_MD on the shared multiply/divide
// unit, which retires one bit per cycle, then commit from S_FIN.
// The result lands in an output register; the next request is accepted
// while it waits. If the receiver stalls with a result still pending, the
// following instruction holds in its final cycle and commits nothing until
// the output register frees up.
// Reset (rst_n, synchronous) empties the stack; RAM contents are not
// cleared, and a pool entry must be written before it is pushed.
module bytecode_stack_calculator_top #(
  parameter int STACK_DEPTH = bsc_pkg::STACK_DEPTH,
  parameter int POOL_DEPTH  = bsc_pkg::POOL_DEPTH,
  parameter int VALUE_WIDTH = bsc_pkg::VALUE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bsc_pkg::CMD_W-1:0]          in_cmd,
  input  logic [bsc_pkg::IDX_W-1:0]          in_pool_index,
  input  logic signed [bsc_pkg::PV_W-1:0]    in_pool_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bsc_pkg::STAT_W-1:0]         out_status,
  output logic                               out_ret_valid,
  output logic signed [bsc_pkg::RET_W-1:0]   out_ret_value,
  output logic                               out_finished
);

  localparam int VW  = VALUE_WIDTH;
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int PAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int IW  = bsc_pkg::IDX_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MD, S_FIN} state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [VW-1:0]                 tos_r, tos_nxt;
  bsc_pkg::cmd_t                 cmd_r;
  logic [IW-1:0]                 idx_r;
  logic [VW-1:0]                 pv_r;

  logic                          out_valid_r;
  bsc_pkg::status_t              out_status_r;
  logic                          out_ret_valid_r;
  logic [bsc_pkg::RET_W-1:0]     out_ret_value_r;
  logic                          out_finished_r;

  logic                          accept, slot_free, commit, idx_ok;
  bsc_pkg::status_t              res_status;
  logic                          res_rv, res_fin;

  logic                          stk_we;
  logic [SAW-1:0]                stk_waddr;
  logic [VW-1:0]                 stk_rdata;
  logic                          pool_we;
  logic [VW-1:0]                 pool_rdata;

  bsc_pkg::md_ctl_t              md_ctl;
  logic                          md_busy, md_done;
  logic [VW-1:0]                 md_res;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign idx_ok    = {1'b0, idx_r} < (IW + 1)'(POOL_DEPTH);
  assign stk_waddr = SAW'(cnt_r - CW'(1));

  // stack RAM holds entries below the top; top of stack lives in tos_r
  bsc_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (tos_r),
    .re    (accept),
    .raddr (SAW'(cnt_r - CW'(2))),
    .rdata (stk_rdata)
  );

  bsc_ram #(.WIDTH(VW), .DEPTH(POOL_DEPTH)) u_pool (
    .clk   (clk),
    .we    (pool_we),
    .waddr (PAW'(idx_r)),
    .wdata (pv_r),
    .re    (accept),
    .raddr (PAW'(in_pool_index)),
    .rdata (pool_rdata)
  );

  bsc_muldiv #(.VALUE_WIDTH(VW)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (md_ctl),
    .a      (stk_rdata),
    .b      (tos_r),
    .busy   (md_busy),
    .done   (md_done),
    .result (md_res)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    tos_nxt    = tos_r;
    commit     = 1'b0;
    res_status = bsc_pkg::ST_OK;
    res_rv     = 1'b0;
    res_fin    = 1'b0;
    stk_we     = 1'b0;
    pool_we    = 1'b0;
    md_ctl     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        commit = slot_free;
        unique case (cmd_r)
          bsc_pkg::CMD_PUSH: begin
            if (cnt_r == CW'(STACK_DEPTH)) begin
              res_status = bsc_pkg::ST_OVER;
            end else if (slot_free) begin
              tos_nxt = idx_ok ? pool_rdata : '0;
              stk_we  = (cnt_r != '0);
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          bsc_pkg::CMD_NEG: begin
            if (cnt_r == '0) begin
              res_status = bsc_pkg::ST_UNDER;
            end else if (slot_free) begin
              tos_nxt = VW'(0) - tos_r;
            end
          end
          bsc_pkg::CMD_ADD, bsc_pkg::CMD_SUB: begin
            if (cnt_r < CW'(2)) begin
              res_status = bsc_pkg::ST_UNDER;
            end else if (slot_free) begin
              tos_nxt = (cmd_r == bsc_pkg::CMD_ADD) ? (stk_rdata + tos_r)
                                                    : (stk_rdata - tos_r);
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          bsc_pkg::CMD_MUL, bsc_pkg::CMD_DIV: begin
            if (cnt_r < CW'(2)) begin
              res_status = bsc_pkg::ST_UNDER;
            end else if (cmd_r == bsc_pkg::CMD_DIV && tos_r == '0) begin
              res_status = bsc_pkg::ST_DIVZ;
            end else begin
              // operands go to the iterative unit; result comes back later
              commit        = 1'b0;
              md_ctl.start  = 1'b1;
              md_ctl.is_div = (cmd_r == bsc_pkg::CMD_DIV);
              state_nxt     = S_MD;
            end
          end
          bsc_pkg::CMD_RET: begin
            res_fin = 1'b1;
            if (cnt_r != '0) begin
              res_rv = 1'b1;
              if (slot_free) begin
                tos_nxt = stk_rdata;
                cnt_nxt = cnt_r - CW'(1);
              end
            end
          end
          bsc_pkg::CMD_WPOOL: begin
            pool_we = slot_free && idx_ok;
          end
          default: ;
        endcase
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      S_MD: begin
        if (md_done) begin
          tos_nxt   = md_res;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        commit = slot_free;
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tos_r   <= tos_nxt;
      if (accept) begin
        cmd_r <= bsc_pkg::cmd_t'(in_cmd);
        idx_r <= in_pool_index;
        pv_r  <= VW'(in_pool_value);
      end
      if (commit) begin
        out_valid_r     <= 1'b1;
        out_status_r    <= res_status;
        out_ret_valid_r <= res_rv;
        out_ret_value_r <= res_rv ? bsc_pkg::RET_W'(tos_r) : '0;
        out_finished_r  <= res_fin;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_ret_valid = out_ret_valid_r;
  assign out_ret_value = out_ret_value_r;
  assign out_finished  = out_finished_r;

  // a faulting instruction leaves the stack depth alone
  a_fault_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res_status != bsc_pkg::ST_OK) |=> $stable(cnt_r))
    else $error("stack depth changed on a faulting instruction");

  // a return that pops drops the depth by exactly one
  a_ret_pops_one: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res_rv) |=> (cnt_r == CW'($past(cnt_r) - CW'(1))))
    else $error("return did not pop exactly one entry");

  // the multiply/divide unit only works while the sequencer waits on it
  a_md_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (md_busy || md_done) |-> (state_r == S_MD))
    else $error("multiply/divide unit active outside its wait state");

  // no new request while a previous one is still in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC && !md_busy))
    else $error("request accepted while another was in flight");

endmodule
